FILE: rtl/pcmfc_pkg.sv
// Shared types, codes and constants for the PCM sample format converter.
`timescale 1ns / 1ps

package pcmfc_pkg;

    // Sample encodings, used for both source and destination
    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_S16 = 2'd1,
        FMT_S24 = 2'd2,
        FMT_F32 = 2'd3
    } t_fmt;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_FMT    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_FMT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_STEREO = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_STEREO = 8'd3;

    // Register values after reset
    localparam t_fmt RST_SRC_FMT    = FMT_S16;
    localparam t_fmt RST_DST_FMT    = FMT_S16;
    localparam logic RST_SRC_STEREO = 1'b0;
    localparam logic RST_DST_STEREO = 1'b0;

    // Sample word width on the channels
    localparam int unsigned SAMPLE_W = 32;

    // Q.32 sample: two's complement, full scale +-2^32, needs 34 bits
    typedef logic [33:0] t_q;
    localparam logic [32:0] Q_ONE = 33'h1_0000_0000;

    // Rescale factors for the signed integer encodings
    localparam logic [22:0] S16_FULL = 23'd32767;
    localparam logic [22:0] S24_FULL = 23'd8388607;

    // Float32 field constants
    localparam logic [7:0] F32_EXP_SPECIAL = 8'hFF;
    localparam logic [7:0] F32_EXP_ONE     = 8'd127;
    localparam logic [7:0] F32_EXP_SHIFT0  = 8'd118;
    localparam logic [7:0] F32_EXP_BIAS_Q  = 8'd95;

    // Load enables of the render stages, one per register stage
    typedef struct packed {
        logic en3;
        logic en4;
        logic en5;
        logic en6;
    } t_pipe_ctl;

endpackage

FILE: rtl/pcmfc_in_if.sv
// Input frame channel: left and right raw sample words plus frame-last flag.
`timescale 1ns / 1ps

interface pcmfc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_raw;
    logic [31:0] right_raw;
    logic        frame_last;

    modport source (output valid, output left_raw, output right_raw, output frame_last,
                    input ready);
    modport sink   (input valid, input left_raw, input right_raw, input frame_last,
                    output ready);
endinterface

FILE: rtl/pcmfc_out_if.sv
// Output frame channel: converted left and right sample words plus last flag.
`timescale 1ns / 1ps

interface pcmfc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] left_out;
    logic [31:0] right_out;
    logic        out_last;

    modport source (output valid, output left_out, output right_out, output out_last,
                    input ready);
    modport sink   (input valid, input left_out, input right_out, input out_last,
                    output ready);
endinterface

FILE: rtl/pcmfc_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps

interface pcmfc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pcmfc_pkg::CFG_IDX_W-1:0]    index;
    logic [pcmfc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/pcmfc_render.sv
// Four-stage renderer: one clamped Q.32 sample to the destination encoding.
`timescale 1ns / 1ps

module pcmfc_render (
    input  logic                  i_clk,
    input  pcmfc_pkg::t_pipe_ctl  i_ctl,
    input  pcmfc_pkg::t_fmt       i_fmt,
    input  pcmfc_pkg::t_q         i_value,
    output logic [31:0]           o_result
);

    // ---------------- stage 3: sign / magnitude, unsigned 8-bit result
    logic        r_s3_sign;
    logic [32:0] r_s3_mag;
    logic [7:0]  r_s3_u8;
    logic        n_s3_sign;
    logic [32:0] n_s3_mag;
    logic [7:0]  n_s3_u8;
    logic [33:0] s3_neg;
    logic [33:0] s3_offs;

    always_comb begin
        s3_neg    = ~i_value + 34'd1;
        // offset binary: v + 1.0 lies in [0, 2^33]
        s3_offs   = i_value + {1'b0, pcmfc_pkg::Q_ONE};
        n_s3_sign = i_value[33];
        n_s3_mag  = i_value[33] ? s3_neg[32:0] : i_value[32:0];
        // 256 only for exactly +1.0, saturate to 255
        n_s3_u8   = s3_offs[33] ? 8'hFF : s3_offs[32:25];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_s3_sign <= n_s3_sign;
            r_s3_mag  <= n_s3_mag;
            r_s3_u8   <= n_s3_u8;
        end
    end

    // ---------------- stage 4: constant multiply, leading-one position
    logic        r_s4_sign;
    logic [32:0] r_s4_mag;
    logic [7:0]  r_s4_u8;
    logic [55:0] r_s4_prod;
    logic [5:0]  r_s4_lead;
    logic [22:0] s4_full;
    logic [55:0] n_s4_prod;
    logic [5:0]  n_s4_lead;

    always_comb begin
        s4_full   = (i_fmt == pcmfc_pkg::FMT_S16) ? pcmfc_pkg::S16_FULL : pcmfc_pkg::S24_FULL;
        n_s4_prod = {23'd0, r_s3_mag} * {33'd0, s4_full};
        n_s4_lead = '0;
        for (int i = 0; i < 33; i++) begin
            if (r_s3_mag[i]) n_s4_lead = 6'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en4) begin
            r_s4_sign <= r_s3_sign;
            r_s4_mag  <= r_s3_mag;
            r_s4_u8   <= r_s3_u8;
            r_s4_prod <= n_s4_prod;
            r_s4_lead <= n_s4_lead;
        end
    end

    // ---------------- stage 5: integer scale with sign, float normalize shift
    logic        r_s5_sign;
    logic        r_s5_zero;
    logic [7:0]  r_s5_u8;
    logic [23:0] r_s5_int;
    logic [32:0] r_s5_norm;
    logic [5:0]  r_s5_lead;
    logic [23:0] s5_trunc;
    logic [23:0] n_s5_int;
    logic [5:0]  s5_shift;
    logic [32:0] n_s5_norm;

    always_comb begin
        // truncation toward zero: scale the magnitude, then apply the sign
        s5_trunc  = r_s4_prod[55:32];
        n_s5_int  = r_s4_sign ? (~s5_trunc + 24'd1) : s5_trunc;
        // put the leading one at bit 32
        s5_shift  = 6'd32 - r_s4_lead;
        n_s5_norm = r_s4_mag << s5_shift;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en5) begin
            r_s5_sign <= r_s4_sign;
            r_s5_zero <= (r_s4_mag == '0);
            r_s5_u8   <= r_s4_u8;
            r_s5_int  <= n_s5_int;
            r_s5_norm <= n_s5_norm;
            r_s5_lead <= r_s4_lead;
        end
    end

    // ---------------- stage 6: float rounding and output select
    logic [31:0] r_s6_word;
    logic [31:0] n_s6_word;
    logic [23:0] s6_mant;
    logic        s6_round_up;
    logic [24:0] s6_mant_rnd;
    logic [7:0]  s6_exp;
    logic [22:0] s6_frac;
    logic [31:0] s6_float;

    always_comb begin
        // round to nearest, ties to even, on the bits below the 24-bit mantissa
        s6_mant     = r_s5_norm[32:9];
        s6_round_up = r_s5_norm[8] & ((|r_s5_norm[7:0]) | r_s5_norm[9]);
        s6_mant_rnd = {1'b0, s6_mant} + {24'd0, s6_round_up};
        if (s6_mant_rnd[24]) begin
            s6_exp  = {2'b00, r_s5_lead} + pcmfc_pkg::F32_EXP_BIAS_Q + 8'd1;
            s6_frac = '0;
        end else begin
            s6_exp  = {2'b00, r_s5_lead} + pcmfc_pkg::F32_EXP_BIAS_Q;
            s6_frac = s6_mant_rnd[22:0];
        end
        s6_float = r_s5_zero ? 32'd0 : {r_s5_sign, s6_exp, s6_frac};

        unique case (i_fmt)
            pcmfc_pkg::FMT_U8:  n_s6_word = {24'd0, r_s5_u8};
            pcmfc_pkg::FMT_S16: n_s6_word = {16'd0, r_s5_int[15:0]};
            pcmfc_pkg::FMT_S24: n_s6_word = {8'd0, r_s5_int};
            pcmfc_pkg::FMT_F32: n_s6_word = s6_float;
            default:            n_s6_word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en6) begin
            r_s6_word <= n_s6_word;
        end
    end

    assign o_result = r_s6_word;

endmodule

FILE: rtl/pcm_sample_format_converter.sv
// PCM sample format converter: output valid rises once an accepted frame reaches stage 6.
// Throughput one frame per cycle while the output is ready; the six register stages hand data forward
// whenever the next stage is empty or moving, so a stall only holds the pipe.
// Synchronous active-low reset clears the stage valid bits and loads the
// configuration defaults (16-bit signed in and out, mono in and out).
`timescale 1ns / 1ps

module pcm_sample_format_converter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    pcmfc_in_if.sink        i_in,
    pcmfc_out_if.source     o_out,
    pcmfc_cfg_if.sink       i_cfg
);

    // ---------------- configuration registers
    pcmfc_pkg::t_fmt r_src_fmt;
    pcmfc_pkg::t_fmt r_dst_fmt;
    logic            r_src_stereo;
    logic            r_dst_stereo;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_fmt    <= pcmfc_pkg::RST_SRC_FMT;
            r_dst_fmt    <= pcmfc_pkg::RST_DST_FMT;
            r_src_stereo <= pcmfc_pkg::RST_SRC_STEREO;
            r_dst_stereo <= pcmfc_pkg::RST_DST_STEREO;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                pcmfc_pkg::CFG_SRC_FMT:    r_src_fmt    <= pcmfc_pkg::t_fmt'(i_cfg.data[1:0]);
                pcmfc_pkg::CFG_DST_FMT:    r_dst_fmt    <= pcmfc_pkg::t_fmt'(i_cfg.data[1:0]);
                pcmfc_pkg::CFG_SRC_STEREO: r_src_stereo <= i_cfg.data[0];
                pcmfc_pkg::CFG_DST_STEREO: r_dst_stereo <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    // ---------------- stage enables: a stage loads when it is empty or drains
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic en1, en2;
    pcmfc_pkg::t_pipe_ctl ctl;

    always_comb begin
        ctl.en6 = !r_v6 || o_out.ready;
        ctl.en5 = !r_v5 || ctl.en6;
        ctl.en4 = !r_v4 || ctl.en5;
        ctl.en3 = !r_v3 || ctl.en4;
        en2     = !r_v2 || ctl.en3;
        en1     = !r_v1 || en2;
    end

    assign i_in.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1)     r_v1 <= i_in.valid;
            if (en2)     r_v2 <= r_v1;
            if (ctl.en3) r_v3 <= r_v2;
            if (ctl.en4) r_v4 <= r_v3;
            if (ctl.en5) r_v5 <= r_v4;
            if (ctl.en6) r_v6 <= r_v5;
        end
    end

    // ---------------- source decode to Q.32
    function automatic pcmfc_pkg::t_q normalize(input logic [31:0] raw,
                                                input pcmfc_pkg::t_fmt fmt);
        logic [7:0]  ex;
        logic [22:0] frac;
        logic [32:0] mant;
        logic [7:0]  lsh;
        logic [7:0]  rsh;
        logic [32:0] mag;
        logic        nan;
        pcmfc_pkg::t_q q;
        ex   = raw[30:23];
        frac = raw[22:0];
        mant = {9'd0, 1'b1, frac};
        lsh  = ex - pcmfc_pkg::F32_EXP_SHIFT0;
        rsh  = pcmfc_pkg::F32_EXP_SHIFT0 - ex;
        nan  = 1'b0;
        // float entry: clamp to +-1.0, truncate magnitude toward zero
        if (ex == pcmfc_pkg::F32_EXP_SPECIAL) begin
            nan = (frac != '0);
            mag = pcmfc_pkg::Q_ONE;
        end else if (ex == 8'd0) begin
            mag = '0;
        end else if (ex >= pcmfc_pkg::F32_EXP_ONE) begin
            mag = pcmfc_pkg::Q_ONE;
        end else if (ex >= pcmfc_pkg::F32_EXP_SHIFT0) begin
            mag = mant << lsh[3:0];
        end else if (rsh >= 8'd32) begin
            mag = '0;
        end else begin
            mag = mant >> rsh[4:0];
        end

        unique case (fmt)
            // offset binary: b - 128 is the byte with its top bit flipped
            pcmfc_pkg::FMT_U8:  q = {~raw[7], ~raw[7], raw[6:0], 25'd0};
            pcmfc_pkg::FMT_S16: q = {raw[15], raw[15:0], 17'd0};
            pcmfc_pkg::FMT_S24: q = {raw[23], raw[23:0], 9'd0};
            pcmfc_pkg::FMT_F32: begin
                if (nan)          q = {1'b0, pcmfc_pkg::Q_ONE};
                else if (raw[31]) q = ~{1'b0, mag} + 34'd1;
                else              q = {1'b0, mag};
            end
            default:            q = '0;
        endcase
        return q;
    endfunction

    // ---------------- stage 1: normalize both channels
    pcmfc_pkg::t_q r_s1_l;
    pcmfc_pkg::t_q r_s1_r;
    logic          r_s1_last;
    pcmfc_pkg::t_q n_s1_l;
    pcmfc_pkg::t_q n_s1_r;

    always_comb begin
        n_s1_l = normalize(i_in.left_raw, r_src_fmt);
        // mono source feeds both channels
        n_s1_r = r_src_stereo ? normalize(i_in.right_raw, r_src_fmt) : n_s1_l;
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_l    <= n_s1_l;
            r_s1_r    <= n_s1_r;
            r_s1_last <= i_in.frame_last;
        end
    end

    // ---------------- stage 2: channel mix (stereo to mono average)
    pcmfc_pkg::t_q r_s2_a;
    pcmfc_pkg::t_q r_s2_b;
    logic          r_s2_last;
    logic [34:0]   s2_sum;
    logic [34:0]   s2_sum_adj;
    pcmfc_pkg::t_q n_s2_a;

    always_comb begin
        s2_sum     = {r_s1_l[33], r_s1_l} + {r_s1_r[33], r_s1_r};
        // add one before the shift when negative so the halving truncates toward zero
        s2_sum_adj = s2_sum + {34'd0, s2_sum[34]};
        if (!r_dst_stereo && r_src_stereo) n_s2_a = s2_sum_adj[34:1];
        else                               n_s2_a = r_s1_l;
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_a    <= n_s2_a;
            r_s2_b    <= r_s1_r;
            r_s2_last <= r_s1_last;
        end
    end

    // ---------------- stages 3 to 6: render each channel
    logic [31:0] left_word;
    logic [31:0] right_word;

    pcmfc_render u_render_left (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_fmt    (r_dst_fmt),
        .i_value  (r_s2_a),
        .o_result (left_word)
    );

    pcmfc_render u_render_right (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_fmt    (r_dst_fmt),
        .i_value  (r_s2_b),
        .o_result (right_word)
    );

    // last flag travels alongside the render stages
    logic r_s3_last, r_s4_last, r_s5_last, r_s6_last;

    always_ff @(posedge i_clk) begin
        if (ctl.en3) r_s3_last <= r_s2_last;
        if (ctl.en4) r_s4_last <= r_s3_last;
        if (ctl.en5) r_s5_last <= r_s4_last;
        if (ctl.en6) r_s6_last <= r_s5_last;
    end

    // ---------------- output word
    assign o_out.valid     = r_v6;
    assign o_out.left_out  = left_word;
    assign o_out.right_out = r_dst_stereo ? right_word : 32'd0;
    assign o_out.out_last  = r_s6_last;

    // ---------------- assertions
    // an accepted word always lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v1)
        else $error("accepted input word did not enter stage 1");

    // an empty first stage never pushes back on the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> i_in.ready)
        else $error("input stalled with stage 1 empty");

    // a full pipe under output stall holds its front stage
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && r_v6 && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted while the full pipeline is stalled");

    // unsigned 8-bit output words use only the low byte
    a_u8_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_dst_fmt == pcmfc_pkg::FMT_U8) |->
            (o_out.left_out[31:8] == 24'd0 && o_out.right_out[31:8] == 24'd0))
        else $error("8-bit output word has high bits set");

endmodule
